### rtl/counting_semaphore_wait_queue_defines.svh
// Assertion macros shared by the semaphore checker.
`ifndef COUNTING_SEMAPHORE_WAIT_QUEUE_DEFINES_SVH
`define COUNTING_SEMAPHORE_WAIT_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define CSWQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cswq: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define CSWQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cswq: next-cycle check failed");

`endif

### rtl/cswq_pkg.sv
// Shared types and constants of the counting semaphore wait queue.
`default_nettype none

package cswq_pkg;

  localparam int ACT_W       = 2;
  localparam int STATUS_W    = 3;
  localparam int COUNT_W     = 18;
  localparam int TID_FIELD_W = 8;
  localparam int INIT_W      = 16;
  localparam int S_TDATA_W   = 24;
  localparam int M_TDATA_W   = 16;

  localparam logic [ACT_W-1:0] ACT_OPEN   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WAIT   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SIGNAL = 2'd2;
  localparam logic [ACT_W-1:0] ACT_CLOSE  = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_CLOSED = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_WOKEN  = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_BUSY   = 3'd4;

  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 18'sd131071;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic do_open;
    logic do_busy;
    logic do_reject;
    logic do_wait;
    logic do_signal;
    logic do_close;
    logic do_pop;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             closed;
    logic             fill_zero;
    logic             fill_one;
    logic             out_free;
  } sts_t;

endpackage

`default_nettype wire

### rtl/cswq_ctrl.sv
// Controller state machine of the semaphore: sequences accept, execute and close drain.
`default_nettype none

module cswq_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire cswq_pkg::sts_t sts_i,
  output cswq_pkg::cmd_t     cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
          if (sts_i.action == cswq_pkg::ACT_OPEN) begin
            if (sts_i.closed) cmd_o.do_open = 1'b1;
            else              cmd_o.do_busy = 1'b1;
          end else if (sts_i.closed) begin
            cmd_o.do_reject = 1'b1;
          end else begin
            case (sts_i.action)
              cswq_pkg::ACT_WAIT:   cmd_o.do_wait   = 1'b1;
              cswq_pkg::ACT_SIGNAL: cmd_o.do_signal = 1'b1;
              cswq_pkg::ACT_CLOSE: begin
                cmd_o.do_close = 1'b1;
                if (!sts_i.fill_zero) state_d = ST_DRAIN;
              end
              default: cmd_o.do_reject = 1'b1;
            endcase
          end
        end
      end
      ST_DRAIN: begin
        if (sts_i.out_free) begin
          cmd_o.do_pop = 1'b1;
          if (sts_i.fill_one) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### rtl/cswq_dp.sv
// Datapath of the semaphore: count, closed flag, waiter memory and result register.
`default_nettype none

module cswq_dp #(
  parameter int WAITER_DEPTH   = 16,
  parameter int THREAD_ID_BITS = 8
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic [cswq_pkg::ACT_W-1:0]           action_i,
  input  wire logic [cswq_pkg::TID_FIELD_W-1:0]     thread_id_i,
  input  wire logic [cswq_pkg::INIT_W-1:0]          init_count_i,
  input  wire cswq_pkg::cmd_t                       cmd_i,
  output cswq_pkg::sts_t                            sts_o,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic [cswq_pkg::STATUS_W-1:0]             status_o,
  output logic                                      caller_blocked_o,
  output logic                                      release_valid_o,
  output logic [cswq_pkg::TID_FIELD_W-1:0]          released_thread_o,
  output logic                                      last_o
);

  localparam int TID_W  = (THREAD_ID_BITS < cswq_pkg::TID_FIELD_W) ?
                          THREAD_ID_BITS : cswq_pkg::TID_FIELD_W;
  localparam int PTR_W  = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1;
  localparam int FILL_W = $clog2(WAITER_DEPTH + 1);
  localparam int SUM_W  = FILL_W + 1;
  localparam logic [PTR_W-1:0]  PTR_LAST   = PTR_W'(WAITER_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_FULL  = FILL_W'(WAITER_DEPTH);
  localparam logic [SUM_W-1:0]  SUM_DEPTH  = SUM_W'(WAITER_DEPTH);

  // Latched item
  logic [cswq_pkg::ACT_W-1:0]  act_q;
  logic [TID_W-1:0]            tid_q;
  logic [cswq_pkg::INIT_W-1:0] init_q;

  // Semaphore state
  logic signed [cswq_pkg::COUNT_W-1:0] count_q, count_d;
  logic                                closed_q, closed_d;
  logic [PTR_W-1:0]                    head_q, head_d;
  logic [FILL_W-1:0]                   fill_q, fill_d;

  // Waiter memory, read through a register at the next head
  logic [TID_W-1:0] mem_q [WAITER_DEPTH];
  logic [TID_W-1:0] rd_q;
  logic             wr_en;
  logic [PTR_W-1:0] tail;
  logic [SUM_W-1:0] tail_sum;

  // Result register
  logic                          out_valid_q;
  logic                          load;
  logic [cswq_pkg::STATUS_W-1:0] status_q, status_d;
  logic                          blocked_q, blocked_d;
  logic                          rel_q, rel_d;
  logic [TID_W-1:0]              rtid_q, rtid_d;
  logic                          last_q, last_d;

  logic count_le0, count_neg, fill_zero, fill_one, full, blocks, releases;
  logic [PTR_W-1:0] head_inc;

  assign count_neg = count_q[cswq_pkg::COUNT_W-1];
  assign count_le0 = count_neg || (count_q == '0);
  assign fill_zero = (fill_q == '0);
  assign fill_one  = (fill_q == FILL_W'(1));
  assign full      = (fill_q >= FILL_FULL);
  assign blocks    = count_le0;
  assign releases  = count_neg && !fill_zero;
  assign head_inc  = (head_q == PTR_LAST) ? '0 : head_q + PTR_W'(1);

  assign tail_sum = SUM_W'(head_q) + SUM_W'(fill_q);
  assign tail     = (tail_sum >= SUM_DEPTH) ? PTR_W'(tail_sum - SUM_DEPTH)
                                            : PTR_W'(tail_sum);

  assign sts_o.action    = act_q;
  assign sts_o.closed    = closed_q;
  assign sts_o.fill_zero = fill_zero;
  assign sts_o.fill_one  = fill_one;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    count_d   = count_q;
    closed_d  = closed_q;
    head_d    = head_q;
    fill_d    = fill_q;
    wr_en     = 1'b0;
    load      = 1'b0;
    status_d  = cswq_pkg::STATUS_OK;
    blocked_d = 1'b0;
    rel_d     = 1'b0;
    rtid_d    = '0;
    last_d    = 1'b1;
    if (cmd_i.do_open) begin
      count_d  = cswq_pkg::COUNT_W'($signed({1'b0, init_q}));
      closed_d = 1'b0;
      head_d   = '0;
      fill_d   = '0;
      load     = 1'b1;
    end
    if (cmd_i.do_busy) begin
      load     = 1'b1;
      status_d = cswq_pkg::STATUS_BUSY;
    end
    if (cmd_i.do_reject) begin
      load     = 1'b1;
      status_d = cswq_pkg::STATUS_CLOSED;
    end
    if (cmd_i.do_wait) begin
      load = 1'b1;
      if (blocks && full) begin
        status_d = cswq_pkg::STATUS_FULL;
      end else begin
        count_d = count_q - cswq_pkg::COUNT_W'(1);
        if (blocks) begin
          wr_en     = 1'b1;
          fill_d    = fill_q + FILL_W'(1);
          blocked_d = 1'b1;
        end
      end
    end
    if (cmd_i.do_signal) begin
      load = 1'b1;
      if (count_q != cswq_pkg::COUNT_MAX) count_d = count_q + cswq_pkg::COUNT_W'(1);
      if (releases) begin
        rel_d  = 1'b1;
        rtid_d = rd_q;
        head_d = head_inc;
        fill_d = fill_q - FILL_W'(1);
      end
    end
    if (cmd_i.do_close) begin
      closed_d = 1'b1;
      count_d  = '0;
      if (fill_zero) begin
        head_d = '0;
        load   = 1'b1;
      end
    end
    if (cmd_i.do_pop) begin
      load     = 1'b1;
      status_d = cswq_pkg::STATUS_WOKEN;
      rel_d    = 1'b1;
      rtid_d   = rd_q;
      last_d   = fill_one;
      fill_d   = fill_q - FILL_W'(1);
      head_d   = fill_one ? '0 : head_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      closed_q    <= 1'b1;
      head_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      closed_q <= closed_d;
      head_q   <= head_d;
      fill_q   <= fill_d;
      if (load)             out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q  <= action_i;
      tid_q  <= thread_id_i[TID_W-1:0];
      init_q <= init_count_i;
    end
    if (load) begin
      status_q  <= status_d;
      blocked_q <= blocked_d;
      rel_q     <= rel_d;
      rtid_q    <= rtid_d;
      last_q    <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[tail] <= tid_q;
    rd_q <= mem_q[head_d];
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign caller_blocked_o  = blocked_q;
  assign release_valid_o   = rel_q;
  assign released_thread_o = cswq_pkg::TID_FIELD_W'(rtid_q);
  assign last_o            = last_q;

endmodule

`default_nettype wire

### rtl/counting_semaphore_wait_queue.sv
// Top level of the counting semaphore with a FIFO queue of blocked thread ids.
//
// Each input beat is one operation (tuser: open, wait, signal, close) on a single counting
// semaphore. Open arms it with init_count, wait takes a unit and queues the caller when the
// count goes negative, signal gives a unit back and hands the oldest waiter to the
// scheduler, close wakes every waiter in arrival order with one result beat each, the final
// one carrying tlast. Every other operation gives exactly one result beat with tlast set.
// Sequencing: operations are taken one at a time (accept, then execute into the output
// register); the next operation is taken while that result waits, and its execute step
// holds until the output register is free. Close with waiters first runs a set-up step
// that gives no result, then drains one waiter per cycle while the output register is free,
// paced by the single registered read port of the waiter memory, which is read ahead at
// the next queue head. No clearing pass is run after reset: queue slots are only read
// after being written.
`default_nettype none

module counting_semaphore_wait_queue #(
  parameter int WAITER_DEPTH   = 16,
  parameter int THREAD_ID_BITS = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Operation beats
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [7:0] thread_id, [23:8] init_count
  input  wire logic [cswq_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // [1:0] action
  input  wire logic [cswq_pkg::ACT_W-1:0]     s_axis_tuser_i,
  // Result beats
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // [2:0] status, [3] caller_blocked, [4] release_valid, [12:5] released_thread,
  // [15:13] zero
  output logic [cswq_pkg::M_TDATA_W-1:0]      m_axis_tdata_o,
  // last result of the operation
  output logic                                m_axis_tlast_o
);

  cswq_pkg::cmd_t cmd;
  cswq_pkg::sts_t sts;

  logic [cswq_pkg::STATUS_W-1:0]    status;
  logic                             caller_blocked;
  logic                             release_valid;
  logic [cswq_pkg::TID_FIELD_W-1:0] released_thread;

  // Sequence operations: accept, execute, drain on close
  cswq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold the semaphore state, the waiter memory and the result register
  cswq_dp #(
    .WAITER_DEPTH   (WAITER_DEPTH),
    .THREAD_ID_BITS (THREAD_ID_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .action_i          (s_axis_tuser_i),
    .thread_id_i       (s_axis_tdata_i[7:0]),
    .init_count_i      (s_axis_tdata_i[23:8]),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (m_axis_tvalid_o),
    .out_ready_i       (m_axis_tready_i),
    .status_o          (status),
    .caller_blocked_o  (caller_blocked),
    .release_valid_o   (release_valid),
    .released_thread_o (released_thread),
    .last_o            (m_axis_tlast_o)
  );

  // Pack the result fields, lowest first; pad to whole bytes
  assign m_axis_tdata_o = {3'b000, released_thread, release_valid, caller_blocked, status};

endmodule

`default_nettype wire

### rtl/cswq_checker.sv
// Port-level checker of the semaphore, bound to the top level.
`default_nettype none

`include "counting_semaphore_wait_queue_defines.svh"

module cswq_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid_i,
  input wire logic                           s_axis_tready_o,
  input wire logic                           m_axis_tvalid_o,
  input wire logic                           m_axis_tready_i,
  input wire logic [cswq_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  input wire logic                           m_axis_tlast_o
);

  logic                          in_beat;
  logic [cswq_pkg::STATUS_W-1:0] status;
  logic                          blocked;
  logic                          rel;

  assign in_beat = s_axis_tvalid_i && s_axis_tready_o;
  assign status  = m_axis_tdata_o[2:0];
  assign blocked = m_axis_tdata_o[3];
  assign rel     = m_axis_tdata_o[4];

  // A result beat stays offered until taken
  `CSWQ_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o)

  // One operation at a time: the input side closes right after a beat
  `CSWQ_ASSERT_NEXT(a_one_at_a_time, in_beat, !s_axis_tready_o)

  // A queued caller is reported as a plain, final ok result with no release
  `CSWQ_ASSERT_NOW(a_blocked_shape, m_axis_tvalid_o && blocked,
                   status == cswq_pkg::STATUS_OK && m_axis_tlast_o && !rel)

  // Every waiter woken by close names a released thread
  `CSWQ_ASSERT_NOW(a_woken_releases, m_axis_tvalid_o && status == cswq_pkg::STATUS_WOKEN,
                   rel && !blocked)

endmodule

bind counting_semaphore_wait_queue cswq_checker u_cswq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire

### test/counting_semaphore_wait_queue_tb.sv
// Self-checking testbench for the counting semaphore with its FIFO of blocked thread ids.
`timescale 1ns / 100ps

module counting_semaphore_wait_queue_tb;

  localparam int QUEUE_DEPTH = 16;
  localparam int HOLD_CYCLES = 120;
  // Far above the slowest clean run, every close draining a full queue under stalls.
  localparam int RUN_LIMIT_NS = 2_000_000;

  // One result beat, field by field.
  typedef struct packed {
    logic [cswq_pkg::STATUS_W-1:0] status;
    logic                          blocked;
    logic                          rel_valid;
    logic [7:0]                    rel_tid;
    logic                          last;
  } sem_beat_t;

  // One row of the directed table. Rows with a typed answer give one beat each.
  typedef struct {
    logic [cswq_pkg::ACT_W-1:0]  act;
    logic [7:0]                  tid;
    logic [cswq_pkg::INIT_W-1:0] init;
    int                          reps;
    bit                          typed;
    sem_beat_t                   answer;
  } op_row_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                           s_tvalid = 1'b0;
  logic [cswq_pkg::S_TDATA_W-1:0] s_tdata  = '0;
  logic [cswq_pkg::ACT_W-1:0]     s_tuser  = cswq_pkg::ACT_OPEN;
  logic                           m_tready = 1'b0;

  wire                            s_tready;
  wire                            m_tvalid;
  wire [cswq_pkg::M_TDATA_W-1:0]  m_tdata;
  wire                            m_tlast;

  counting_semaphore_wait_queue #(
    .WAITER_DEPTH   (QUEUE_DEPTH),
    .THREAD_ID_BITS (8)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Predicted semaphore state, advanced once per accepted operation beat.
  int         sem_count;
  bit         sem_closed;
  logic [7:0] waiter_ring [QUEUE_DEPTH];
  int         ring_head;
  int         ring_fill;

  sem_beat_t  op_beats [$];    // beats of the operation just predicted
  sem_beat_t  pending_beats [$];  // beats still owed by the block

  int mismatches = 0;

  // Idling knobs. The sender's is read only by the main process.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_ticket = 0;
  int hold_seen   = 0;
  int hold_left   = 0;

  function automatic sem_beat_t mk_beat(logic [cswq_pkg::STATUS_W-1:0] status, logic blocked,
                                        logic rel_valid, logic [7:0] rel_tid, logic last);
    sem_beat_t b;
    b.status    = status;
    b.blocked   = blocked;
    b.rel_valid = rel_valid;
    b.rel_tid   = rel_tid;
    b.last      = last;
    return b;
  endfunction

  function automatic logic [7:0] pop_waiter();
    logic [7:0] t;
    t = waiter_ring[ring_head];
    ring_head = (ring_head + 1) % QUEUE_DEPTH;
    ring_fill--;
    return t;
  endfunction

  // Work out the result beats of one operation and advance the predicted state.
  function automatic void predict_sem_op(logic [cswq_pkg::ACT_W-1:0] act, logic [7:0] tid,
                                         logic [cswq_pkg::INIT_W-1:0] init);
    logic [7:0] t;
    op_beats.delete();
    if (act == cswq_pkg::ACT_OPEN) begin
      if (!sem_closed) begin
        op_beats.push_back(mk_beat(cswq_pkg::STATUS_BUSY, 1'b0, 1'b0, 8'h00, 1'b1));
      end else begin
        sem_count  = int'(init);
        sem_closed = 1'b0;
        ring_head  = 0;
        ring_fill  = 0;
        op_beats.push_back(mk_beat(cswq_pkg::STATUS_OK, 1'b0, 1'b0, 8'h00, 1'b1));
      end
    end else if (sem_closed) begin
      op_beats.push_back(mk_beat(cswq_pkg::STATUS_CLOSED, 1'b0, 1'b0, 8'h00, 1'b1));
    end else begin
      case (act)
        cswq_pkg::ACT_WAIT: begin
          if (sem_count - 1 < 0) begin
            if (ring_fill >= QUEUE_DEPTH) begin
              op_beats.push_back(mk_beat(cswq_pkg::STATUS_FULL, 1'b0, 1'b0, 8'h00, 1'b1));
            end else begin
              sem_count--;
              waiter_ring[(ring_head + ring_fill) % QUEUE_DEPTH] = tid;
              ring_fill++;
              op_beats.push_back(mk_beat(cswq_pkg::STATUS_OK, 1'b1, 1'b0, 8'h00, 1'b1));
            end
          end else begin
            sem_count--;
            op_beats.push_back(mk_beat(cswq_pkg::STATUS_OK, 1'b0, 1'b0, 8'h00, 1'b1));
          end
        end
        cswq_pkg::ACT_SIGNAL: begin
          // Saturate rather than wrap at the top of the 18-bit signed range.
          if (sem_count < int'(cswq_pkg::COUNT_MAX)) sem_count++;
          if (sem_count <= 0 && ring_fill > 0) begin
            t = pop_waiter();
            op_beats.push_back(mk_beat(cswq_pkg::STATUS_OK, 1'b0, 1'b1, t, 1'b1));
          end else begin
            op_beats.push_back(mk_beat(cswq_pkg::STATUS_OK, 1'b0, 1'b0, 8'h00, 1'b1));
          end
        end
        default: begin
          sem_closed = 1'b1;
          sem_count  = 0;
          if (ring_fill == 0) begin
            op_beats.push_back(mk_beat(cswq_pkg::STATUS_OK, 1'b0, 1'b0, 8'h00, 1'b1));
          end else begin
            // Wake every waiter oldest first; tlast on the final one.
            while (ring_fill > 0) begin
              t = pop_waiter();
              op_beats.push_back(mk_beat(cswq_pkg::STATUS_WOKEN, 1'b0, 1'b1, t,
                                         ring_fill == 0));
            end
          end
          ring_head = 0;
        end
      endcase
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: result %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Offer one operation beat, hold it until taken, then book its results.
  // Called on a rising edge; returns on the edge that accepted the beat.
  task automatic send_op(logic [cswq_pkg::ACT_W-1:0] act, logic [7:0] tid,
                         logic [cswq_pkg::INIT_W-1:0] init,
                         bit typed = 1'b0, sem_beat_t answer = '0);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {init, tid};
    s_tuser  <= act;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    predict_sem_op(act, tid, init);
    if (typed) begin
      pending_beats.push_back(answer);
    end else begin
      foreach (op_beats[i]) pending_beats.push_back(op_beats[i]);
    end
  endtask

  // Drop valid and hold off until the block owes nothing.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_beats.size() != 0) @(posedge clk_i);
  endtask

  // Random operations: mostly well-formed open/use/close episodes with random content,
  // the rest single noise beats; some episodes are left open, so a noise open may bounce as busy.
  task automatic run_random(int n_items);
    int                          sent;
    int                          len;
    int                          wait_pct;
    int                          r;
    logic [7:0]                  tid;
    logic [cswq_pkg::INIT_W-1:0] init;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(7) == 0) begin
        tid  = 8'($urandom);
        init = cswq_pkg::INIT_W'($urandom);
        send_op(cswq_pkg::ACT_W'($urandom_range(3)), tid, init);
        sent++;
      end else begin
        tid  = 8'($urandom);
        init = cswq_pkg::INIT_W'($urandom);
        send_op(cswq_pkg::ACT_CLOSE, tid, init);
        r = $urandom_range(9);
        if (r < 6)       init = cswq_pkg::INIT_W'($urandom_range(3));
        else if (r < 8)  init = cswq_pkg::INIT_W'($urandom);
        else if (r == 8) init = 16'hFFFF;
        else             init = 16'h0000;
        tid = 8'($urandom);
        send_op(cswq_pkg::ACT_OPEN, tid, init);
        len      = $urandom_range(28, 4);
        wait_pct = $urandom_range(90, 35);
        for (int i = 0; i < len; i++) begin
          r    = $urandom_range(99);
          tid  = 8'($urandom);
          init = cswq_pkg::INIT_W'($urandom);
          if (r < wait_pct)  send_op(cswq_pkg::ACT_WAIT, tid, init);
          else if (r < 97)   send_op(cswq_pkg::ACT_SIGNAL, tid, init);
          else               send_op(cswq_pkg::ACT_OPEN, tid, init);
        end
        if ($urandom_range(3) != 0) begin
          tid  = 8'($urandom);
          init = cswq_pkg::INIT_W'($urandom);
          send_op(cswq_pkg::ACT_CLOSE, tid, init);
        end
        sent += len + 3;
      end
    end
  endtask

  // Result side: hold off for a long stretch when asked, otherwise idle at random.
  always @(posedge clk_i) begin
    if (hold_ticket != hold_seen) begin
      hold_seen <= hold_ticket;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Compare every accepted result beat with the oldest one owed.
  always @(posedge clk_i) begin
    sem_beat_t want;
    if (rst_n && m_tvalid && m_tready) begin
      if (pending_beats.size() == 0) begin
        report_mismatch("unexpected beat tdata", int'(m_tdata), 0);
      end else begin
        want = pending_beats.pop_front();
        if (m_tdata[2:0] !== want.status)
          report_mismatch("status", int'(m_tdata[2:0]), int'(want.status));
        if (m_tdata[3] !== want.blocked)
          report_mismatch("caller_blocked", int'(m_tdata[3]), int'(want.blocked));
        if (m_tdata[4] !== want.rel_valid)
          report_mismatch("release_valid", int'(m_tdata[4]), int'(want.rel_valid));
        if (m_tdata[12:5] !== want.rel_tid)
          report_mismatch("released_thread", int'(m_tdata[12:5]), int'(want.rel_tid));
        if (m_tlast !== want.last)
          report_mismatch("last", int'(m_tlast), int'(want.last));
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

  initial begin
    op_row_t                     plan [$];
    op_row_t                     row;
    logic [7:0]                  tid;
    logic [cswq_pkg::INIT_W-1:0] init;

    // Directed table: typed answers where they are plain, the predictor for the rest.
    row = '{cswq_pkg::ACT_WAIT,   8'h5A, 16'h0000, 1, 1'b1,
            mk_beat(cswq_pkg::STATUS_CLOSED, 1'b0, 1'b0, 8'h00, 1'b1)};
    plan.push_back(row);
    row = '{cswq_pkg::ACT_SIGNAL, 8'hA5, 16'hFFFF, 1, 1'b1,
            mk_beat(cswq_pkg::STATUS_CLOSED, 1'b0, 1'b0, 8'h00, 1'b1)};
    plan.push_back(row);
    row = '{cswq_pkg::ACT_CLOSE,  8'hFF, 16'h1234, 1, 1'b1,
            mk_beat(cswq_pkg::STATUS_CLOSED, 1'b0, 1'b0, 8'h00, 1'b1)};
    plan.push_back(row);
    row = '{cswq_pkg::ACT_OPEN,   8'h00, 16'h0000, 1, 1'b1,
            mk_beat(cswq_pkg::STATUS_OK, 1'b0, 1'b0, 8'h00, 1'b1)};
    plan.push_back(row);
    row = '{cswq_pkg::ACT_OPEN,   8'hFF, 16'hFFFF, 1, 1'b1,
            mk_beat(cswq_pkg::STATUS_BUSY, 1'b0, 1'b0, 8'h00, 1'b1)};
    plan.push_back(row);
    row = '{cswq_pkg::ACT_WAIT,   8'h00, 16'hFFFF, 1, 1'b1,
            mk_beat(cswq_pkg::STATUS_OK, 1'b1, 1'b0, 8'h00, 1'b1)};
    plan.push_back(row);
    row = '{cswq_pkg::ACT_WAIT,   8'hFF, 16'h0000, 1, 1'b1,
            mk_beat(cswq_pkg::STATUS_OK, 1'b1, 1'b0, 8'h00, 1'b1)};
    plan.push_back(row);
    row = '{cswq_pkg::ACT_SIGNAL, 8'h33, 16'h0000, 1, 1'b1,
            mk_beat(cswq_pkg::STATUS_OK, 1'b0, 1'b1, 8'h00, 1'b1)};
    plan.push_back(row);
    row = '{cswq_pkg::ACT_SIGNAL, 8'h00, 16'hFFFF, 1, 1'b1,
            mk_beat(cswq_pkg::STATUS_OK, 1'b0, 1'b1, 8'hFF, 1'b1)};
    plan.push_back(row);
    row = '{cswq_pkg::ACT_SIGNAL, 8'h00, 16'h0000, 1, 1'b1,
            mk_beat(cswq_pkg::STATUS_OK, 1'b0, 1'b0, 8'h00, 1'b1)};
    plan.push_back(row);
    row = '{cswq_pkg::ACT_WAIT,   8'h11, 16'h0000, 1, 1'b1,
            mk_beat(cswq_pkg::STATUS_OK, 1'b0, 1'b0, 8'h00, 1'b1)};
    plan.push_back(row);
    // Fill the waiter queue to the brim, then knock on it once more.
    row = '{cswq_pkg::ACT_WAIT,   8'hE0, 16'h0000, QUEUE_DEPTH, 1'b1,
            mk_beat(cswq_pkg::STATUS_OK, 1'b1, 1'b0, 8'h00, 1'b1)};
    plan.push_back(row);
    row = '{cswq_pkg::ACT_WAIT,   8'h77, 16'h0000, 1, 1'b1,
            mk_beat(cswq_pkg::STATUS_FULL, 1'b0, 1'b0, 8'h00, 1'b1)};
    plan.push_back(row);
    row = '{cswq_pkg::ACT_CLOSE,  8'h00, 16'h0000, 1, 1'b0, '0};
    plan.push_back(row);
    row = '{cswq_pkg::ACT_WAIT,   8'h01, 16'h0000, 1, 1'b1,
            mk_beat(cswq_pkg::STATUS_CLOSED, 1'b0, 1'b0, 8'h00, 1'b1)};
    plan.push_back(row);
    row = '{cswq_pkg::ACT_OPEN,   8'h00, 16'hFFFF, 1, 1'b1,
            mk_beat(cswq_pkg::STATUS_OK, 1'b0, 1'b0, 8'h00, 1'b1)};
    plan.push_back(row);
    row = '{cswq_pkg::ACT_WAIT,   8'h80, 16'h8000, 1, 1'b1,
            mk_beat(cswq_pkg::STATUS_OK, 1'b0, 1'b0, 8'h00, 1'b1)};
    plan.push_back(row);
    row = '{cswq_pkg::ACT_CLOSE,  8'h00, 16'h0000, 1, 1'b1,
            mk_beat(cswq_pkg::STATUS_OK, 1'b0, 1'b0, 8'h00, 1'b1)};
    plan.push_back(row);
    row = '{cswq_pkg::ACT_OPEN,   8'h00, 16'h0002, 1, 1'b0, '0};
    plan.push_back(row);
    row = '{cswq_pkg::ACT_WAIT,   8'h3C, 16'h0000, 3, 1'b0, '0};
    plan.push_back(row);
    row = '{cswq_pkg::ACT_CLOSE,  8'hC3, 16'h0000, 1, 1'b0, '0};
    plan.push_back(row);

    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Phase one: sender idles a little, receiver a lot.
    tx_idle_pct = 23;
    rx_idle_pct <= 68;
    foreach (plan[i]) begin
      for (int k = 0; k < plan[i].reps; k++) begin
        tid = 8'(plan[i].tid + k);
        send_op(plan[i].act, tid, plan[i].init, plan[i].typed, plan[i].answer);
      end
    end
    run_random(60);

    // Phase two: the other way round.
    tx_idle_pct = 68;
    rx_idle_pct <= 23;
    run_random(55);

    // Phase three: no idling; stall the result side for a long stretch while
    // beats keep coming, so the block backs up onto its input.
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    hold_ticket <= hold_ticket + 1;
    run_random(55);

    // Pause the sender until the block owes nothing, then run a short episode
    // from a quiet block: open at the largest initial count and count upwards.
    drain_results();
    send_op(cswq_pkg::ACT_CLOSE, 8'h00, 16'h0000);
    send_op(cswq_pkg::ACT_OPEN, 8'h00, 16'hFFFF);
    for (int i = 0; i < 4; i++) begin
      tid  = 8'($urandom);
      init = cswq_pkg::INIT_W'($urandom);
      send_op(cswq_pkg::ACT_SIGNAL, tid, init);
    end
    send_op(cswq_pkg::ACT_WAIT, 8'h42, 16'h0000);
    send_op(cswq_pkg::ACT_CLOSE, 8'h00, 16'h0000);

    // Wait for the tail, then let the block run on idle in case it misbehaves.
    drain_results();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
